@@ sv/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// Timer table package
// Shared types and codes for the software timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam logic [47:0] MaxTime = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    CmdCreateOnce  = 3'd0,
    CmdCreateRep   = 3'd1,
    CmdDelete      = 3'd2,
    CmdTick        = 3'd3,
    CmdForeground  = 3'd4,
    CmdBackground  = 3'd5,
    CmdSpare6      = 3'd6,
    CmdSpare7      = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    KindAck     = 3'd0,
    KindFired   = 3'd1,
    KindNone    = 3'd2,
    KindFull    = 3'd3,
    KindPresent = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StAct,
    StFind,
    StFire,
    StMin,
    StEmit
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] timer_id;
    logic [31:0] delay_ms;
    logic [47:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] fired_id;
    logic [47:0] next_deadline;
    logic        last;
  } out_word_t;

endpackage

@@ sv/stt_if.sv @@
// ----------------------------------------------------------------------------
// Timer table channel
// Valid/ready channel that carries one word of a given type.
// ----------------------------------------------------------------------------
interface stt_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/software_timer_table.sv @@
// ----------------------------------------------------------------------------
// Software timer table
// Table of one-shot and recurring timers keyed by id, with expiry checks.
// ----------------------------------------------------------------------------
// One command is taken at a time; in_ch is ready only while the sequencer is
// idle. One 48-bit comparator pair and one saturating adder walk the slots one
// per cycle. A create or delete makes one pass to find the id and the first
// free slot, takes one action step, makes one pass for the earliest remaining
// deadline and then loads its word. Foreground in foreground, background,
// unused codes and a tick in background skip to the minimum pass. A check
// that fires k timers spends one search pass plus one fire step per timer,
// then one empty search pass (left out once sixteen have fired) and the
// minimum pass before its first word comes, and the further words follow
// one per cycle while the receiver keeps up. A stalled receiver holds the
// sequencer in its emit step.
module software_timer_table #(
  parameter int NUM_TIMERS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  stt_if.sink   in_ch,
  stt_if.source out_ch
);
  import stt_pkg::*;

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(NUM_TIMERS - 1);
  localparam logic [4:0] MaxOut = 5'd16;

  logic [NUM_TIMERS-1:0] valid_q, valid_d;
  logic [31:0] id_q [NUM_TIMERS];
  logic [47:0] dl_q [NUM_TIMERS];
  logic [31:0] per_q [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] rep_q;
  logic fg_q, fg_d;

  state_e state_q, state_d;
  in_word_t cmd_q, cmd_d;
  logic [IW-1:0] idx_q, idx_d;
  // Match/free/best slot found during a pass.
  logic hit_q, hit_d, free_ok_q, free_ok_d, best_ok_q, best_ok_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d, best_q, best_d;
  logic [47:0] min_q, min_d;
  logic [NUM_TIMERS-1:0] done_q, done_d;   // slots already fired in this check
  logic [4:0] fired_q, fired_d;
  logic [4:0] rd_q, rd_d;
  kind_e kind_q, kind_d;
  logic [31:0] sid_q, sid_d;
  logic [31:0] fid_q [16];
  out_word_t ow_q, ow_d;
  logic ov_q, ov_d;

  // Shared unit: one slot compared per cycle.
  logic [47:0] cur_dl;
  logic cur_v, cur_exp, cur_lt;
  logic [47:0] add_a;
  logic [31:0] add_b;
  logic [48:0] sum;
  logic [47:0] adv;
  assign cur_dl = dl_q[idx_q];
  assign cur_v = valid_q[idx_q];
  assign cur_exp = cur_v && !done_q[idx_q] && (cur_dl <= cmd_q.now_ms);
  assign cur_lt = cur_dl < min_q;
  assign sum = {1'b0, add_a} + {17'd0, add_b};
  assign adv = sum[48] ? MaxTime : sum[47:0];

  logic wr_new, wr_adv, fid_we;
  logic [IW-1:0] wr_idx;

  assign in_ch.ready = (state_q == StIdle);
  assign out_ch.valid = ov_q;
  assign out_ch.data = ow_q;

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    idx_d = idx_q;
    hit_d = hit_q; hit_idx_d = hit_idx_q;
    free_ok_d = free_ok_q; free_idx_d = free_idx_q;
    best_ok_d = best_ok_q; best_d = best_q;
    min_d = min_q;
    done_d = done_q;
    fired_d = fired_q;
    rd_d = rd_q;
    kind_d = kind_q;
    sid_d = sid_q;
    valid_d = valid_q;
    fg_d = fg_q;
    ow_d = ow_q;
    ov_d = ov_q;
    add_a = cmd_q.now_ms;
    add_b = cmd_q.delay_ms;
    wr_new = 1'b0;
    wr_adv = 1'b0;
    fid_we = 1'b0;
    wr_idx = best_q;
    if (ov_q && out_ch.ready) begin
      ov_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_ch.valid) begin
          cmd_d = in_ch.data;
          idx_d = '0;
          hit_d = 1'b0; free_ok_d = 1'b0; best_ok_d = 1'b0;
          min_d = MaxTime;
          done_d = '0;
          fired_d = '0;
          kind_d = KindAck;
          sid_d = '0;
          case (cmd_e'(in_ch.data.command))
            CmdCreateOnce, CmdCreateRep, CmdDelete: state_d = StScan;
            CmdTick: begin
              kind_d = KindNone;
              state_d = fg_q ? StFind : StMin;
            end
            CmdForeground: begin
              if (!fg_q) begin
                fg_d = 1'b1;
                kind_d = KindNone;
                state_d = StFind;
              end else begin
                state_d = StMin;
              end
            end
            CmdBackground: begin
              fg_d = 1'b0;
              state_d = StMin;
            end
            default: state_d = StMin;
          endcase
        end
      end
      // Pass over all slots: id match and first free slot.
      StScan: begin
        if (cur_v && id_q[idx_q] == cmd_q.timer_id && !hit_q) begin
          hit_d = 1'b1;
          hit_idx_d = idx_q;
        end
        if (!cur_v && !free_ok_q) begin
          free_ok_d = 1'b1;
          free_idx_d = idx_q;
        end
        idx_d = idx_q + IW'(1);
        if (idx_q == LastIdx) begin
          idx_d = '0;
          state_d = StAct;
        end
      end
      StAct: begin
        state_d = StMin;
        case (cmd_e'(cmd_q.command))
          CmdCreateOnce, CmdCreateRep: begin
            if (cmd_q.command == CmdCreateOnce && cmd_q.delay_ms == '0) begin
              // A zero-delay one-shot fires at once and also fires a stored twin.
              kind_d = KindFired;
              sid_d = cmd_q.timer_id;
              if (hit_q) begin
                add_a = dl_q[hit_idx_q];
                add_b = per_q[hit_idx_q];
                wr_idx = hit_idx_q;
                if (rep_q[hit_idx_q]) wr_adv = 1'b1;
                else valid_d[hit_idx_q] = 1'b0;
              end
            end else if (hit_q) begin
              kind_d = KindPresent;
            end else if (!free_ok_q) begin
              kind_d = KindFull;
            end else begin
              wr_new = 1'b1;
              wr_idx = free_idx_q;
              valid_d[free_idx_q] = 1'b1;
            end
          end
          CmdDelete: begin
            if (hit_q) valid_d[hit_idx_q] = 1'b0;
          end
          default: begin
          end
        endcase
      end
      // Search for the earliest expired slot not yet fired; ties keep the lower slot.
      StFind: begin
        if (cur_exp && (!best_ok_q || cur_lt)) begin
          best_ok_d = 1'b1;
          best_d = idx_q;
          min_d = cur_dl;
        end
        idx_d = idx_q + IW'(1);
        if (idx_q == LastIdx) begin
          idx_d = '0;
          if (best_ok_d) begin
            state_d = StFire;
          end else begin
            min_d = MaxTime;
            state_d = StMin;
          end
        end
      end
      StFire: begin
        add_a = dl_q[best_q];
        add_b = per_q[best_q];
        wr_idx = best_q;
        if (rep_q[best_q]) wr_adv = 1'b1;
        else valid_d[best_q] = 1'b0;
        done_d[best_q] = 1'b1;
        fid_we = 1'b1;
        fired_d = fired_q + 5'd1;
        best_ok_d = 1'b0;
        min_d = MaxTime;
        idx_d = '0;
        state_d = (fired_d == MaxOut) ? StMin : StFind;
      end
      StMin: begin
        if (cur_v && cur_lt) min_d = cur_dl;
        idx_d = idx_q + IW'(1);
        if (idx_q == LastIdx) begin
          idx_d = '0;
          rd_d = '0;
          state_d = StEmit;
        end
      end
      // Every word of the command carries the minimum over the final table.
      StEmit: begin
        if (!ov_q || out_ch.ready) begin
          ov_d = 1'b1;
          ow_d.next_deadline = min_q;
          if (fired_q == '0) begin
            ow_d.kind = kind_q;
            ow_d.fired_id = sid_q;
            ow_d.last = 1'b1;
            state_d = StIdle;
          end else begin
            ow_d.kind = KindFired;
            ow_d.fired_id = fid_q[rd_q[3:0]];
            ow_d.last = (rd_q + 5'd1 == fired_q);
            rd_d = rd_q + 5'd1;
            if (rd_q + 5'd1 == fired_q) state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      fg_q <= 1'b1;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      fg_q <= fg_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    hit_q <= hit_d; hit_idx_q <= hit_idx_d;
    free_ok_q <= free_ok_d; free_idx_q <= free_idx_d;
    best_ok_q <= best_ok_d; best_q <= best_d;
    min_q <= min_d;
    done_q <= done_d;
    fired_q <= fired_d;
    rd_q <= rd_d;
    kind_q <= kind_d;
    sid_q <= sid_d;
    ow_q <= ow_d;
    if (fid_we) fid_q[fired_q[3:0]] <= id_q[best_q];
    if (wr_new) begin
      id_q[wr_idx] <= cmd_q.timer_id;
      dl_q[wr_idx] <= adv;
      per_q[wr_idx] <= cmd_q.delay_ms;
      rep_q[wr_idx] <= (cmd_q.command == CmdCreateRep);
    end else if (wr_adv) begin
      dl_q[wr_idx] <= adv;
    end
  end

endmodule
